[hdl/jtl_pkg.sv]
// jtl_pkg: shared types, token kinds and character helpers for the json token lexer
// used by jtl_front, jtl_back, json_token_lexer_top and jtl_checker
package jtl_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int HOLD_MAX    = 4;
  localparam int Q_DEPTH     = 4;
  localparam int OUT_DEPTH   = 4;

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef enum logic [3:0] {
    KIND_FALSE, KIND_TRUE, KIND_NULL, KIND_NUMBER, KIND_STRING, KIND_LBRACKET,
    KIND_LBRACE, KIND_RBRACKET, KIND_COMMA, KIND_RBRACE, KIND_COLON, KIND_EOF,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    kind_t       token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [7:0] text_byte;
    off_t       pos;
    logic       end_mark;
    logic       step_last;
  } elem_t;

  function automatic off_t sat_add(off_t a, off_t b);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
      || c == 8'h5f || c[7];
  endfunction

  // w: 0 true, 1 false, 2 null
  function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    case (w)
      2'd0: begin
        case (k)
          3'd1: r = "r";
          3'd2: r = "u";
          3'd3: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (k)
          3'd1: r = "a";
          3'd2: r = "l";
          3'd3: r = "s";
          3'd4: r = "e";
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (k)
          3'd1: r = "u";
          3'd2: r = "l";
          3'd3: r = "l";
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] w);
    return (w == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic kind_t kw_kind(logic [1:0] w);
    kind_t r;
    case (w)
      2'd0: r = KIND_TRUE;
      2'd1: r = KIND_FALSE;
      default: r = KIND_NULL;
    endcase
    return r;
  endfunction

endpackage

[hdl/jtl_front.sv]
// jtl_front: accepts text bytes, tracks the offset and splits each word into
// byte and end-of-text elements held in a short queue; depends on jtl_pkg
module jtl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  jtl_pkg::item_t      item,
  output logic                q_valid,
  output jtl_pkg::elem_t      q_head,
  input  logic                q_pop
);

  localparam int AW = $clog2(jtl_pkg::Q_DEPTH);

  jtl_pkg::elem_t mem [jtl_pkg::Q_DEPTH];
  logic [AW-1:0]  head;
  logic [AW:0]    count;
  jtl_pkg::off_t  position;

  logic           accept;
  logic           doc_end;
  logic           has_byte;
  jtl_pkg::off_t  pos_inc;
  jtl_pkg::elem_t e0;
  jtl_pkg::elem_t e1;
  logic [1:0]     n_wr;
  logic [AW-1:0]  tail;
  logic [AW:0]    count_next;

  assign full    = count > (AW+1)'(jtl_pkg::Q_DEPTH - 2);
  assign accept  = push && !full;
  assign q_valid = count != '0;
  assign q_head  = mem[head];
  assign tail    = head + count[AW-1:0];

  always_comb begin
    has_byte = item.text_byte != 8'h00;
    doc_end  = !has_byte || item.end_of_text;
    pos_inc  = jtl_pkg::sat_add(position, jtl_pkg::off_t'(1));
    e1 = '{text_byte: 8'h00, pos: pos_inc, end_mark: 1'b1, step_last: 1'b1};
    if (has_byte) begin
      e0 = '{text_byte: item.text_byte, pos: position, end_mark: 1'b0, step_last: !doc_end};
    end else begin
      e0 = '{text_byte: 8'h00, pos: position, end_mark: 1'b1, step_last: 1'b1};
    end
    n_wr = 2'd0;
    if (accept) begin
      n_wr = (has_byte && doc_end) ? 2'd2 : 2'd1;
    end
    count_next = count + (AW+1)'(n_wr) - (AW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      position <= '0;
    end else begin
      if (n_wr != 2'd0) begin
        mem[tail] <= e0;
      end
      if (n_wr == 2'd2) begin
        mem[tail + AW'(1)] <= e1;
      end
      if (accept) begin
        position <= doc_end ? '0 : pos_inc;
      end
      if (q_pop && q_valid) begin
        head <= head + AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

[hdl/jtl_back.sv]
// jtl_back: lexer state machine over queued elements, replay of held bytes,
// and the result queue; depends on jtl_pkg
module jtl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  jtl_pkg::elem_t q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output jtl_pkg::res_t  token
);

  localparam int OW = $clog2(jtl_pkg::OUT_DEPTH);

  typedef enum logic [3:0] {
    M_IDLE, M_STR, M_ESC, M_KT, M_KF, M_KN, M_MINUS, M_ZERO, M_INT,
    M_DOT, M_FRAC, M_E, M_ESIGN, M_EXP
  } mode_t;

  mode_t         mode, mode_next;
  jtl_pkg::off_t start, start_next;
  jtl_pkg::off_t run, run_next;
  logic [2:0]    kwp, kwp_next;
  logic [7:0]    held [jtl_pkg::HOLD_MAX];
  logic [7:0]    held_next [jtl_pkg::HOLD_MAX];
  logic [2:0]    hc, hc_next;
  logic [7:0]    rbytes [jtl_pkg::HOLD_MAX];
  logic [2:0]    rcount, rcount_next;
  logic [2:0]    ridx, ridx_next;
  jtl_pkg::off_t rbase, rbase_next;
  jtl_pkg::res_t pend;
  logic          pend_v;

  jtl_pkg::res_t omem [jtl_pkg::OUT_DEPTH];
  logic [OW-1:0] ohead;
  logic [OW:0]   ocount;

  logic          rvalid, room, go, consumed, fail, load_replay;
  logic [7:0]    c;
  jtl_pkg::off_t p;
  logic          e_end;
  logic [1:0]    w;
  logic          em;
  jtl_pkg::kind_t em_kind;
  jtl_pkg::off_t em_start, em_len;
  logic          step_end;
  jtl_pkg::res_t newres, d0, d1;
  logic [1:0]    n_wr;
  logic          pend_load, pend_clear;
  logic [OW-1:0] otail;

  assign rvalid = ridx < rcount;
  assign room   = ocount <= (OW+1)'(jtl_pkg::OUT_DEPTH - 2);
  assign go     = (rvalid || q_valid) && room;
  assign c      = rvalid ? rbytes[ridx[1:0]] : q_head.text_byte;
  assign e_end  = rvalid ? 1'b0 : q_head.end_mark;
  assign p      = rvalid ? jtl_pkg::sat_add(rbase, jtl_pkg::off_t'(ridx)) : q_head.pos;
  assign empty  = ocount == '0;
  assign token  = omem[ohead];
  assign otail  = ohead + ocount[OW-1:0];

  always_comb begin
    case (mode)
      M_KF:    w = 2'd1;
      M_KN:    w = 2'd2;
      default: w = 2'd0;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    start_next  = start;
    run_next    = run;
    kwp_next    = kwp;
    held_next   = held;
    hc_next     = hc;
    rcount_next = rcount;
    ridx_next   = ridx;
    rbase_next  = rbase;
    em          = 1'b0;
    em_kind     = jtl_pkg::KIND_ERROR;
    em_start    = start;
    em_len      = run;
    consumed    = 1'b0;
    fail        = 1'b0;
    load_replay = 1'b0;
    if (go) begin
      case (mode)
        M_IDLE: begin
          consumed = 1'b1;
          if (e_end) begin
            em = 1'b1; em_kind = jtl_pkg::KIND_EOF; em_start = p; em_len = '0;
            start_next = '0; run_next = '0; kwp_next = '0; hc_next = '0;
          end else begin
            start_next = p;
            run_next   = jtl_pkg::off_t'(1);
            hc_next    = '0;
            em_start   = p;
            em_len     = jtl_pkg::off_t'(1);
            case (c)
              "\"": mode_next = M_STR;
              "[": begin em = 1'b1; em_kind = jtl_pkg::KIND_LBRACKET; end
              "{": begin em = 1'b1; em_kind = jtl_pkg::KIND_LBRACE; end
              "]": begin em = 1'b1; em_kind = jtl_pkg::KIND_RBRACKET; end
              ",": begin em = 1'b1; em_kind = jtl_pkg::KIND_COMMA; end
              "}": begin em = 1'b1; em_kind = jtl_pkg::KIND_RBRACE; end
              ":": begin em = 1'b1; em_kind = jtl_pkg::KIND_COLON; end
              "t": begin mode_next = M_KT; kwp_next = 3'd1; end
              "f": begin mode_next = M_KF; kwp_next = 3'd1; end
              "n": begin mode_next = M_KN; kwp_next = 3'd1; end
              "-": mode_next = M_MINUS;
              "0": mode_next = M_ZERO;
              default: begin
                if (jtl_pkg::is_digit(c)) begin
                  mode_next = M_INT;
                end else if (!jtl_pkg::is_space(c)) begin
                  em = 1'b1; em_kind = jtl_pkg::KIND_ERROR;
                end
              end
            endcase
          end
        end
        M_STR, M_ESC: begin
          if (e_end) begin
            em = 1'b1; em_kind = jtl_pkg::KIND_ERROR; mode_next = M_IDLE;
          end else begin
            consumed = 1'b1;
            run_next = jtl_pkg::sat_add(run, jtl_pkg::off_t'(1));
            if (mode == M_ESC) begin
              mode_next = M_STR;
            end else if (c == "\\") begin
              mode_next = M_ESC;
            end else if (c == "\"") begin
              em = 1'b1; em_kind = jtl_pkg::KIND_STRING; em_len = run_next;
              mode_next = M_IDLE;
            end
          end
        end
        M_KT, M_KF, M_KN: begin
          if (kwp < jtl_pkg::kw_len(w)) begin
            if (!e_end && kwp >= 3'd1 && c == jtl_pkg::kw_char(w, kwp)) begin
              consumed = 1'b1;
              held_next[2'(kwp - 3'd1)] = c;
              hc_next  = kwp;
              kwp_next = kwp + 3'd1;
            end else begin
              fail = 1'b1;
            end
          end else if (!e_end && jtl_pkg::is_ident(c)) begin
            fail = 1'b1;
          end else begin
            em = 1'b1; em_kind = jtl_pkg::kw_kind(w);
            em_len = jtl_pkg::off_t'(jtl_pkg::kw_len(w));
            hc_next = '0; mode_next = M_IDLE;
          end
        end
        M_MINUS: begin
          if (!e_end && jtl_pkg::is_digit(c)) begin
            consumed  = 1'b1;
            run_next  = jtl_pkg::sat_add(run, jtl_pkg::off_t'(1));
            mode_next = (c == "0") ? M_ZERO : M_INT;
          end else begin
            em = 1'b1; em_kind = jtl_pkg::KIND_ERROR; em_len = jtl_pkg::off_t'(1);
            mode_next = M_IDLE;
          end
        end
        M_ZERO, M_INT, M_FRAC, M_EXP: begin
          if (!e_end && jtl_pkg::is_digit(c) && mode != M_ZERO) begin
            consumed = 1'b1;
            run_next = jtl_pkg::sat_add(run, jtl_pkg::off_t'(1));
          end else if (!e_end && c == "." && (mode == M_ZERO || mode == M_INT)) begin
            consumed = 1'b1; mode_next = M_DOT;
            if (hc < 3'(jtl_pkg::HOLD_MAX)) begin
              held_next[hc[1:0]] = c; hc_next = hc + 3'd1;
            end
          end else if (!e_end && (c == "e" || c == "E") && mode != M_EXP) begin
            consumed = 1'b1; mode_next = M_E;
            if (hc < 3'(jtl_pkg::HOLD_MAX)) begin
              held_next[hc[1:0]] = c; hc_next = hc + 3'd1;
            end
          end else begin
            em = 1'b1; em_kind = jtl_pkg::KIND_NUMBER; mode_next = M_IDLE;
          end
        end
        M_DOT, M_E, M_ESIGN: begin
          if (!e_end && jtl_pkg::is_digit(c)) begin
            consumed  = 1'b1;
            run_next  = jtl_pkg::sat_add(run, jtl_pkg::off_t'(hc + 3'd1));
            hc_next   = '0;
            mode_next = (mode == M_DOT) ? M_FRAC : M_EXP;
          end else if (!e_end && mode == M_E && (c == "+" || c == "-")) begin
            consumed = 1'b1; mode_next = M_ESIGN;
            if (hc < 3'(jtl_pkg::HOLD_MAX)) begin
              held_next[hc[1:0]] = c; hc_next = hc + 3'd1;
            end
          end else begin
            fail = 1'b1;
          end
        end
        default: mode_next = M_IDLE;
      endcase
      if (fail) begin
        em = 1'b1;
        if (mode == M_KT || mode == M_KF || mode == M_KN) begin
          em_kind = jtl_pkg::KIND_ERROR; em_len = jtl_pkg::off_t'(1);
        end else begin
          em_kind = jtl_pkg::KIND_NUMBER;
        end
        load_replay = 1'b1;
        rbase_next  = jtl_pkg::sat_add(start, run);
        rcount_next = hc;
        ridx_next   = '0;
        hc_next     = '0;
        mode_next   = M_IDLE;
      end else if (consumed && rvalid) begin
        ridx_next = ridx + 3'd1;
      end
    end
  end

  assign q_pop    = consumed && !rvalid;
  assign step_end = q_pop && q_head.step_last;

  always_comb begin
    newres = '{token_kind: em_kind, token_start: 16'(em_start),
               token_length: 16'(em_len), last_of_run: step_end};
    d0 = pend; d0.last_of_run = 1'b0;
    d1 = newres;
    n_wr = 2'd0;
    pend_load = 1'b0;
    pend_clear = 1'b0;
    if (em) begin
      if (pend_v && step_end) begin
        n_wr = 2'd2; pend_clear = 1'b1;
      end else if (pend_v) begin
        n_wr = 2'd1; pend_load = 1'b1;
      end else if (step_end) begin
        n_wr = 2'd1; d0 = newres;
      end else begin
        pend_load = 1'b1;
      end
    end else if (step_end && pend_v) begin
      n_wr = 2'd1; d0.last_of_run = 1'b1; pend_clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      start  <= '0;
      run    <= '0;
      kwp    <= '0;
      hc     <= '0;
      rcount <= '0;
      ridx   <= '0;
      pend_v <= 1'b0;
      ohead  <= '0;
      ocount <= '0;
    end else begin
      mode   <= mode_next;
      start  <= start_next;
      run    <= run_next;
      kwp    <= kwp_next;
      hc     <= hc_next;
      rcount <= rcount_next;
      ridx   <= ridx_next;
      if (pend_load) begin
        pend_v <= 1'b1;
      end else if (pend_clear) begin
        pend_v <= 1'b0;
      end
      if (pop && !empty) begin
        ohead <= ohead + OW'(1);
      end
      ocount <= ocount + (OW+1)'(n_wr) - (OW+1)'(pop && !empty);
    end
    held  <= held_next;
    rbase <= rbase_next;
    if (load_replay) begin
      rbytes <= held;
    end
    if (pend_load) begin
      pend <= newres;
    end
    if (n_wr != 2'd0) begin
      omem[otail] <= d0;
    end
    if (n_wr == 2'd2) begin
      omem[otail + OW'(1)] <= d1;
    end
  end

endmodule

[hdl/json_token_lexer_top.sv]
// json_token_lexer_top: streaming json tokenizer, front element queue plus back lexer
// depends on jtl_pkg, jtl_front, jtl_back
//
//   channel  dir  handshake          word
//   item     in   push / full        jtl_pkg::item_t (text_byte, end_of_text)
//   token    out  pop / empty        jtl_pkg::res_t (kind, start, length, last_of_run)
//
// one byte per cycle while full is low; the back lexer handles one element a cycle while the result queue has room
// a closing token reprocesses its byte, and a failed keyword or number step replays
// its held bytes (up to four); a byte flagged end_of_text adds an element for eof
// reset is synchronous and empties both queues; no clearing pass is needed
// full rises while the element queue lacks room for two elements, and the lexer
// pauses while the result queue lacks room for two words
module json_token_lexer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  jtl_pkg::item_t item,
  output logic           empty,
  input  logic           pop,
  output jtl_pkg::res_t  token
);

  logic           q_valid;
  logic           q_pop;
  jtl_pkg::elem_t q_head;

  jtl_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  jtl_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .empty(empty), .pop(pop), .token(token)
  );

endmodule

[hdl/jtl_checker.sv]
// jtl_props: port-level checks on the json token lexer result stream
// depends on jtl_pkg; bound to json_token_lexer_top
module jtl_props (
  input logic           clk,
  input logic           rst,
  input logic           push,
  input logic           full,
  input jtl_pkg::item_t item,
  input logic           empty,
  input logic           pop,
  input jtl_pkg::res_t  token
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(token))
    else $error("stalled token word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> token.token_kind <= jtl_pkg::KIND_ERROR)
    else $error("token kind out of range");

  a_eof: assert property (@(posedge clk) disable iff (rst)
    !empty && token.token_kind == jtl_pkg::KIND_EOF |->
      token.token_length == 16'd0 && token.last_of_run)
    else $error("eof token malformed");

  a_reset: assert property (@(posedge clk)
    $fell(rst) |-> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind json_token_lexer_top jtl_props u_chk (.*);
